// File: design/ctim_pkg.sv
`timescale 1ns / 1ps

package ctim_pkg;

    // Item kinds carried on the input tuser.
    localparam logic [1:0] ACT_WRITE_A   = 2'd0;
    localparam logic [1:0] ACT_WRITE_B   = 2'd1;
    localparam logic [1:0] ACT_WRITE_P   = 2'd2;
    localparam logic [1:0] ACT_READ      = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_INNER_LENGTH = 3'd0;
    localparam logic [2:0] REG_OUT_SHIFT    = 3'd1;
    localparam logic [2:0] REG_ROUND_MODE   = 3'd2;
    localparam logic [2:0] REG_SATURATE     = 3'd3;
    localparam logic [2:0] REG_CASCADE_ROLE = 3'd4;

    // Cascade roles.
    localparam logic [1:0] ROLE_SINGLE = 2'd0;
    localparam logic [1:0] ROLE_FIRST  = 2'd1;
    localparam logic [1:0] ROLE_MIDDLE = 2'd2;
    localparam logic [1:0] ROLE_LAST   = 2'd3;

    // Field widths and stream packing.
    localparam int IDX_W    = 6;
    localparam int ELEM_W   = 16;
    localparam int PART_W   = 48;
    localparam int RESULT_W = 48;
    localparam int S_DATA_W = 80;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic signed [15:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SAT_MIN = 16'sh8000;

    // Narrowing settings handed from the top level to the output stage.
    typedef struct packed {
        logic [5:0] shift;
        logic       round_half_up;
        logic       saturate;
    } narrow_cfg_t;

endpackage

// File: design/ctim_narrow.sv
`timescale 1ns / 1ps

// Two-step narrowing of the accumulator: the arithmetic shift and the
// rounding bit are registered on load, then round, clamp or wrap.
module ctim_narrow
    import ctim_pkg::*;
(
    input  logic               clk,
    input  logic               load,
    input  logic signed [63:0] acc,
    input  narrow_cfg_t        cfg,
    output logic signed [15:0] result
);

    logic signed [63:0] q_reg;
    logic               rbit_reg;
    logic               sat_reg;
    logic signed [63:0] q_rounded;
    logic               fits;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg    <= acc >>> cfg.shift;
            rbit_reg <= cfg.round_half_up && (cfg.shift != 6'd0) && acc[cfg.shift - 6'd1];
            sat_reg  <= cfg.saturate;
        end
    end

    always_comb
    begin
        q_rounded = q_reg + 64'(rbit_reg);
        fits      = (&q_rounded[63:15]) || !(|q_rounded[63:15]);
        if (sat_reg && !fits)
        begin
            result = q_rounded[63] ? SAT_MIN : SAT_MAX;
        end
        else
        begin
            result = q_rounded[15:0];
        end
    end

endmodule

// File: design/cascaded_tiled_int_matmul_top.sv
`timescale 1ns / 1ps

// Integer matrix multiply stage for a cascade of such stages.
// Input stream (s_*): each item either stores one element of A (row, inner),
// one element of B (inner, column), one partial accumulator (row, column), or
// asks for one result element (row, column). Writes keep s_tready high and give
// no result item. A read item occupies the block: s_tready stays low while one
// multiply-accumulate unit walks the inner dimension, one product per cycle.
// After acceptance a read passes a start state that loads the accumulator, the
// multiply-accumulate state, which streams the clamped inner length of products
// through one multiplier behind the memory read and product registers and ends
// once that pipe is empty, a shift state and the output register. The next item
// is taken only when the read is done, so reads do not overlap.
// Output stream (m_*): the result item sits in an output register until taken.
// The block accepts new items while a result waits; a following read stalls
// in its final cycle until the output register is free, so nothing is lost.
// First and middle roles return the raw accumulator with m_tuser set; single
// and last roles return the shifted, rounded, clamped or wrapped 16-bit value.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Reset (rst_n low, asynchronous) returns the sequencer to idle, drops
// m_tvalid and restores the register defaults. The element and partial
// memories are not cleared; reading an entry never written gives garbage.
module cascaded_tiled_int_matmul_top
    import ctim_pkg::*;
#(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_INNER = 64,
    parameter int MAX_COLS  = 64,
    parameter int ACC_WIDTH = 48
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // row_index[5:0], col_index[11:6], element_value[27:12],
    // partial_value[75:28], zero fill above
    input  logic [S_DATA_W-1:0]   s_tdata,
    // action[1:0]
    input  logic [S_USER_W-1:0]   s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // result_value[47:0]
    output logic [M_DATA_W-1:0]   m_tdata,
    // is_raw_accumulator[0]
    output logic [0:0]            m_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int RW = $clog2(MAX_ROWS);
    localparam int IW = $clog2(MAX_INNER);
    localparam int CW = $clog2(MAX_COLS);
    localparam int KW = $clog2(MAX_INNER + 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_MAC   = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    // Element and partial memories.
    logic [ELEM_W-1:0]    a_mem [2**(RW+IW)];
    logic [ELEM_W-1:0]    b_mem [2**(IW+CW)];
    logic [ACC_WIDTH-1:0] p_mem [2**(RW+CW)];

    // Configuration registers.
    logic [6:0] inner_length_reg;
    logic [5:0] out_shift_reg;
    logic       round_mode_reg;
    logic       saturate_enable_reg;
    logic [1:0] cascade_role_reg;

    logic [2:0]    state_reg, state_next;
    logic [KW-1:0] k_reg, k_next;
    logic [KW-1:0] n_reg;
    logic          v1_reg, v1_next;
    logic          v2_reg, v2_next;
    logic          inrange_reg;
    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_reg;
    logic          m_valid_reg, m_valid_next;

    logic signed [ELEM_W-1:0]    a_rd_reg, b_rd_reg;
    logic        [ACC_WIDTH-1:0] p_rd_reg;
    logic signed [31:0]          prod_reg;
    logic signed [ACC_WIDTH-1:0] acc_reg;
    logic [M_DATA_W-1:0]         m_data_reg;
    logic                        m_raw_reg;

    // Input fields.
    logic [1:0]  action;
    logic [8:0]  row9, col9, len9, n9;
    logic [ELEM_W-1:0] element_value;
    logic [PART_W-1:0] partial_value;
    logic        accept;
    logic        a_ok, b_ok, p_ok, rd_ok;
    logic        issue;
    logic        mac_done;
    logic        out_free;
    logic        raw_role;

    logic [RW+IW-1:0] a_raddr;
    logic [IW+CW-1:0] b_raddr;

    logic signed [63:0] acc64;
    logic signed [15:0] narrow_result;
    narrow_cfg_t        ncfg;

    assign action        = s_tuser;
    assign row9          = 9'(s_tdata[5:0]);
    assign col9          = 9'(s_tdata[11:6]);
    assign element_value = s_tdata[27:12];
    assign partial_value = s_tdata[75:28];

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    assign a_ok  = (row9 < 9'(MAX_ROWS))  && (col9 < 9'(MAX_INNER));
    assign b_ok  = (row9 < 9'(MAX_INNER)) && (col9 < 9'(MAX_COLS));
    assign p_ok  = (row9 < 9'(MAX_ROWS))  && (col9 < 9'(MAX_COLS));
    assign rd_ok = p_ok;

    // Inner length clamped to the A/B storage depth.
    assign len9 = 9'(inner_length_reg);
    assign n9   = (len9 > 9'(MAX_INNER)) ? 9'(MAX_INNER) : len9;

    assign raw_role = (cascade_role_reg == ROLE_FIRST) || (cascade_role_reg == ROLE_MIDDLE);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_length_reg    <= 7'd64;
            out_shift_reg       <= 6'd0;
            round_mode_reg      <= 1'b0;
            saturate_enable_reg <= 1'b1;
            cascade_role_reg    <= ROLE_SINGLE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INNER_LENGTH: inner_length_reg    <= cfg_data;
                REG_OUT_SHIFT:    out_shift_reg       <= cfg_data[5:0];
                REG_ROUND_MODE:   round_mode_reg      <= cfg_data[0];
                REG_SATURATE:     saturate_enable_reg <= cfg_data[0];
                REG_CASCADE_ROLE: cascade_role_reg    <= cfg_data[1:0];
                default:          ;
            endcase
        end
    end

    // Memory writes come straight from accepted write items; reads are
    // registered. The partial port reads at the incoming item's address so
    // the start value is ready in the cycle after a read is accepted.
    assign a_raddr = {row_reg, k_reg[IW-1:0]};
    assign b_raddr = {k_reg[IW-1:0], col_reg};

    always_ff @(posedge clk)
    begin
        if (accept && (action == ACT_WRITE_A) && a_ok)
        begin
            a_mem[{row9[RW-1:0], col9[IW-1:0]}] <= element_value;
        end
        a_rd_reg <= a_mem[a_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (accept && (action == ACT_WRITE_B) && b_ok)
        begin
            b_mem[{row9[IW-1:0], col9[CW-1:0]}] <= element_value;
        end
        b_rd_reg <= b_mem[b_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (accept && (action == ACT_WRITE_P) && p_ok)
        begin
            p_mem[{row9[RW-1:0], col9[CW-1:0]}] <= ACC_WIDTH'($signed(partial_value));
        end
        p_rd_reg <= p_mem[{row9[RW-1:0], col9[CW-1:0]}];
    end

    // Sequencer: one address issued per cycle, memory read and product
    // registers behind it, the accumulator closes the loop.
    assign issue    = (state_reg == S_MAC) && inrange_reg && (k_reg < n_reg);
    assign mac_done = !issue && !v1_reg && !v2_reg;
    assign out_free = !m_valid_reg || m_tready;

    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        v1_next      = issue;
        v2_next      = v1_reg;
        m_valid_next = m_valid_reg && !m_tready;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (action == ACT_READ))
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                k_next     = '0;
                state_next = S_MAC;
            end
            S_MAC:
            begin
                if (issue)
                begin
                    k_next = k_reg + 1'b1;
                end
                if (mac_done)
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            k_reg       <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept && (action == ACT_READ))
        begin
            row_reg     <= row9[RW-1:0];
            col_reg     <= col9[CW-1:0];
            inrange_reg <= rd_ok;
            n_reg       <= n9[KW-1:0];
        end
        prod_reg <= a_rd_reg * b_rd_reg;
        if (state_reg == S_LOAD)
        begin
            if (inrange_reg && cascade_role_reg[1])
            begin
                acc_reg <= p_rd_reg;
            end
            else
            begin
                acc_reg <= '0;
            end
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + ACC_WIDTH'(prod_reg);
        end
        if ((state_reg == S_OUT) && out_free)
        begin
            m_data_reg <= raw_role ? acc64[RESULT_W-1:0] : RESULT_W'(narrow_result);
            m_raw_reg  <= raw_role;
        end
    end

    assign acc64 = 64'(acc_reg);

    assign ncfg.shift         = out_shift_reg;
    assign ncfg.round_half_up = round_mode_reg;
    assign ncfg.saturate      = saturate_enable_reg;

    ctim_narrow u_narrow (
        .clk    (clk),
        .load   (state_reg == S_SHIFT),
        .acc    (acc64),
        .cfg    (ncfg),
        .result (narrow_result)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_raw_reg;

endmodule

// File: design/ctim_checker.sv
`timescale 1ns / 1ps

module ctim_checker
    import ctim_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_USER_W-1:0] s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // A read item occupies the block in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == ACT_READ) |=> !s_tready)
        else $error("block took a new item right after a read");

    // Write items never produce a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser != ACT_READ) && !m_tvalid |=> !m_tvalid)
        else $error("result appeared after a write item");

    // A new result only appears at the end of a busy period.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared while the block was idle");

endmodule

bind cascaded_tiled_int_matmul_top ctim_checker u_ctim_checker (.*);

// File: tb/tb_cascaded_tiled_int_matmul_top.sv
`timescale 1ns / 1ps

// Self-checking bench for one stage of the cascaded integer matrix multiply.
// Stimulus loads A, B and partial entries and issues reads. Every read is
// preceded by whatever writes it needs, so no entry is ever read before it
// holds a value. A small tracker class mirrors the three stores and the
// registers, predicts each read, and checks the output stream in order.
module tb_cascaded_tiled_int_matmul_top;
    import ctim_pkg::*;

    localparam int DIM            = 64;
    // Longest read is 64 terms plus the pipeline registers; allow margin.
    localparam int SETTLE_CYCLES  = 80;
    // One read plus the longest sender gap and the longest receiver stall
    // stays far below this.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TARGET_ITEMS   = 1100;
    localparam int ACC_W_TB       = 48;

    typedef struct {
        logic [RESULT_W-1:0] value;
        logic                raw;
        int                  row;
        int                  col;
    } expected_result_t;

    // Mirror of the block: stores, registers and the queue of reads in flight.
    class matmul_result_tracker;
        logic signed [ELEM_W-1:0] a_mem [DIM][DIM];
        logic signed [ELEM_W-1:0] b_mem [DIM][DIM];
        logic signed [PART_W-1:0] part_mem [DIM][DIM];
        logic [6:0]               inner_len = 7'd64;
        logic [5:0]               shift     = 6'd0;
        logic                     round_up  = 1'b0;
        logic                     saturate  = 1'b1;
        logic [1:0]               role      = ROLE_SINGLE;
        expected_result_t         pending_results [$];
        int                       failures;
        int                       results_checked;

        function void set_config(logic [6:0] inner, logic [5:0] sh, logic rnd,
                                 logic sat, logic [1:0] rl);
            inner_len = inner;
            shift     = sh;
            round_up  = rnd;
            saturate  = sat;
            role      = rl;
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= 10)
                $display("[%0t] MISMATCH: %s", $time, msg);
        endfunction

        function expected_result_t predict_element(logic [5:0] row, logic [5:0] col);
            expected_result_t r;
            logic signed [ACC_W_TB-1:0] acc;
            longint wide;
            longint q;
            int terms;
            acc = (role == ROLE_MIDDLE || role == ROLE_LAST) ? part_mem[row][col] : '0;
            terms = (inner_len > 7'd64) ? DIM : int'(inner_len);
            // Products are formed at accumulator width, so the sum wraps there.
            for (int k = 0; k < terms; k++)
                acc = acc + a_mem[row][k] * b_mem[k][col];
            r.row = row;
            r.col = col;
            r.raw = (role == ROLE_FIRST || role == ROLE_MIDDLE);
            if (r.raw) begin
                r.value = acc;
            end
            else begin
                wide = acc;
                q = wide >>> shift;
                // Half-up rounding adds back the last bit that was shifted out.
                if (round_up && shift != 6'd0)
                    q = q + ((wide >>> (shift - 6'd1)) & 64'sd1);
                if (saturate) begin
                    if (q > 32767)
                        q = 32767;
                    else if (q < -32768)
                        q = -32768;
                end
                else begin
                    q = {{48{q[15]}}, q[15:0]};
                end
                r.value = q[RESULT_W-1:0];
            end
            return r;
        endfunction

        function void note_input(logic [1:0] act, logic [5:0] row, logic [5:0] col,
                                 logic [15:0] elem, logic [47:0] part);
            case (act)
                ACT_WRITE_A: a_mem[row][col] = elem;
                ACT_WRITE_B: b_mem[row][col] = elem;
                ACT_WRITE_P: part_mem[row][col] = part;
                ACT_READ:    pending_results.push_back(predict_element(row, col));
                default: ;
            endcase
        endfunction

        function void check_result(logic [RESULT_W-1:0] value, logic raw);
            expected_result_t want;
            if (pending_results.size() == 0) begin
                note_failure($sformatf("result %h raw %b with no read outstanding",
                                       value, raw));
                return;
            end
            want = pending_results.pop_front();
            results_checked++;
            if (value !== want.value)
                note_failure($sformatf("read (%0d,%0d) value: expected %h, got %h",
                                       want.row, want.col, want.value, value));
            if (raw !== want.raw)
                note_failure($sformatf("read (%0d,%0d) raw flag: expected %b, got %b",
                                       want.row, want.col, want.raw, raw));
        endfunction

        function void close_out();
            while (pending_results.size() != 0) begin
                note_failure($sformatf("read (%0d,%0d) never answered",
                                       pending_results[0].row, pending_results[0].col));
                void'(pending_results.pop_front());
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // row_index[5:0], col_index[11:6], element_value[27:12],
    // partial_value[75:28], zero fill above
    logic [S_DATA_W-1:0]   s_tdata;
    // action[1:0]
    logic [S_USER_W-1:0]   s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // result_value[47:0]
    logic [M_DATA_W-1:0]   m_tdata;
    // is_raw_accumulator[0]
    logic [0:0]            m_tuser;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    matmul_result_tracker tracker;

    // Which entries hold a value; reads are only issued over loaded entries.
    bit a_loaded [DIM][DIM];
    bit b_loaded [DIM][DIM];
    bit p_loaded [DIM][DIM];

    bit gaps_on;
    int stall_left;
    int items_sent;
    int settings_run;
    int cur_inner;
    int cur_role;

    cascaded_tiled_int_matmul_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Element values lean on the extremes and on small numbers that do not
    // saturate, with the rest spread over the whole range.
    function automatic logic [15:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return SAT_MIN;
            1: return SAT_MAX;
            2: return 16'($urandom_range(0, 16)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [47:0] rand_part();
        case ($urandom_range(0, 5))
            0: return 48'h7FFF_FFFF_FFFF;
            1: return 48'h8000_0000_0000;
            2: return 48'($urandom_range(0, 4000)) - 48'd2000;
            default: return {16'($urandom), $urandom};
        endcase
    endfunction

    // With long inner lengths a read needs a whole row and column loaded, so
    // those reads stay on the corner rows and columns where the loads pay off.
    function automatic logic [5:0] pick_index();
        if (cur_inner > 16)
            return ($urandom_range(0, 1) != 0) ? 6'd63 : 6'd0;
        if ($urandom_range(0, 1) != 0)
            return 6'($urandom_range(0, 63));
        return 6'($urandom_range(0, 7));
    endfunction

    // Sends one item. Called at a rising edge; returns at the edge where the
    // item was accepted, with tvalid still high so the next item can follow
    // without a bubble.
    task automatic send_item(input logic [1:0] act, input logic [5:0] row,
                             input logic [5:0] col, input logic [15:0] elem,
                             input logic [47:0] part);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {4'b0, part, elem, col, row};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tracker.note_input(act, row, col, elem, part);
        case (act)
            ACT_WRITE_A: a_loaded[row][col] = 1'b1;
            ACT_WRITE_B: b_loaded[row][col] = 1'b1;
            ACT_WRITE_P: p_loaded[row][col] = 1'b1;
            default: ;
        endcase
        items_sent++;
    endtask

    // A read preceded by loads of every entry it will touch that is still
    // empty. The unused data fields of the read carry random bits.
    task automatic read_with_fill(input logic [5:0] row, input logic [5:0] col);
        int terms;
        terms = (cur_inner > DIM) ? DIM : cur_inner;
        for (int k = 0; k < terms; k++)
            if (!a_loaded[row][k])
                send_item(ACT_WRITE_A, row, 6'(k), rand_elem(), rand_part());
        for (int k = 0; k < terms; k++)
            if (!b_loaded[k][col])
                send_item(ACT_WRITE_B, 6'(k), col, rand_elem(), rand_part());
        if ((cur_role == ROLE_MIDDLE || cur_role == ROLE_LAST) && !p_loaded[row][col])
            send_item(ACT_WRITE_P, row, col, rand_elem(), rand_part());
        send_item(ACT_READ, row, col, rand_elem(), rand_part());
    endtask

    // Stops sending, waits for every outstanding read to come back, then lets
    // the pipeline run dry so that register writes land on an idle block.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all five registers on consecutive edges. Only called while idle.
    task automatic program_regs(input int inner, input int shift, input int rnd,
                                input int sat, input int role);
        cfg_we    <= 1'b1;
        cfg_index <= REG_INNER_LENGTH;
        cfg_data  <= 7'(inner);
        @(posedge clk);
        cfg_index <= REG_OUT_SHIFT;
        cfg_data  <= 7'(shift);
        @(posedge clk);
        cfg_index <= REG_ROUND_MODE;
        cfg_data  <= 7'(rnd);
        @(posedge clk);
        cfg_index <= REG_SATURATE;
        cfg_data  <= 7'(sat);
        @(posedge clk);
        cfg_index <= REG_CASCADE_ROLE;
        cfg_data  <= 7'(role);
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.set_config(7'(inner), 6'(shift), 1'(rnd), 1'(sat), 2'(role));
        cur_inner = inner;
        cur_role  = role;
        // Every third setting runs with both sides at full rate.
        gaps_on = (settings_run % 3) != 2;
        settings_run++;
    endtask

    // One register setting: mostly read sequences, the rest stray writes
    // anywhere in the stores.
    task automatic run_phase(input int inner, input int shift, input int rnd,
                             input int sat, input int role, input int count);
        int stop_at;
        drain_results();
        program_regs(inner, shift, rnd, sat, role);
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) < 6)
                read_with_fill(pick_index(), pick_index());
            else
                send_item(2'($urandom_range(ACT_WRITE_A, ACT_WRITE_P)),
                          6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                          rand_elem(), rand_part());
        end
    endtask

    // Result side: take and check results, with random stalls on tready.
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_tvalid && m_tready)
                tracker.check_result(m_tdata, m_tuser[0]);
            if (gaps_on && stall_left == 0 && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run if no item moves on any port for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no item moved for %0d cycles, %0d reads outstanding",
                 WATCHDOG_LIMIT, tracker.pending_results.size());
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = ACT_WRITE_A;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_INNER_LENGTH;
        cfg_data  = '0;
        gaps_on   = 1'b0;
        tracker   = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with one term and the last role, so each read is
        // partial + a*b. Field extremes, accumulator wrap past the top end,
        // saturation at the low end and a few small values that pass unclamped.
        program_regs(1, 0, 0, 1, ROLE_LAST);
        send_item(ACT_WRITE_A, 0, 0, SAT_MIN, '0);
        send_item(ACT_WRITE_B, 0, 0, SAT_MIN, '0);
        send_item(ACT_WRITE_P, 0, 0, '0, 48'h7FFF_FFFF_FFFF);
        send_item(ACT_READ, 0, 0, '0, '0);
        send_item(ACT_WRITE_A, 63, 0, SAT_MAX, '0);
        send_item(ACT_WRITE_B, 0, 63, SAT_MAX, '0);
        send_item(ACT_WRITE_P, 63, 63, 16'hFFFF, 48'h8000_0000_0000);
        send_item(ACT_READ, 63, 63, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
        send_item(ACT_WRITE_P, 0, 63, '0, 48'd5);
        send_item(ACT_READ, 0, 63, SAT_MAX, 48'h7FFF_FFFF_FFFF);
        send_item(ACT_WRITE_P, 63, 0, '0, '1);
        send_item(ACT_READ, 63, 0, SAT_MIN, 48'h8000_0000_0000);
        send_item(ACT_WRITE_A, 1, 0, 16'd3, '0);
        send_item(ACT_WRITE_B, 0, 1, 16'hFFFE, '0);
        send_item(ACT_WRITE_P, 1, 1, '0, 48'd7);
        send_item(ACT_READ, 1, 1, '0, '0);
        send_item(ACT_WRITE_A, 2, 0, 16'hFFFF, '0);
        send_item(ACT_WRITE_B, 0, 2, 16'hFFFF, '0);
        send_item(ACT_WRITE_P, 2, 2, '0, '0);
        send_item(ACT_READ, 2, 2, '0, '0);

        // Fixed settings: every role, zero and clamped inner length, full
        // length reads, shifts from none to past the accumulator width.
        run_phase(4,   0,  0, 1, ROLE_SINGLE, 130);
        run_phase(8,   47, 1, 1, ROLE_LAST,   100);
        run_phase(3,   10, 1, 0, ROLE_MIDDLE, 130);
        run_phase(0,   5,  0, 0, ROLE_FIRST,  50);
        run_phase(0,   3,  1, 1, ROLE_LAST,   40);
        run_phase(64,  20, 1, 1, ROLE_SINGLE, 200);
        run_phase(127, 63, 1, 0, ROLE_LAST,   60);
        run_phase(64,  31, 0, 0, ROLE_FIRST,  40);
        run_phase(1,   1,  1, 0, ROLE_MIDDLE, 80);
        run_phase(2,   15, 1, 1, ROLE_LAST,   80);

        // Random settings until the item count is reached.
        while (items_sent < TARGET_ITEMS)
            run_phase($urandom_range(1, 12), $urandom_range(0, 47), $urandom_range(0, 1),
                      $urandom_range(0, 1), $urandom_range(ROLE_SINGLE, ROLE_LAST),
                      $urandom_range(60, 120));

        drain_results();
        tracker.close_out();
        $display("Sent %0d items and checked %0d reads over %0d register settings,",
                 items_sent, tracker.results_checked, settings_run);
        $display("covering all four roles, both rounding and both overflow modes.");
        if (tracker.failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
